@@ hdl/pot_pkg.sv @@
// Shared types and constants of the priority override table.
// Holds slot geometry, command and result records, status codes and FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pot_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // command queue between front and back; depth must be a power of two
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KIND_PUSH,
    KIND_REJECT,
    KIND_REMOVE,
    KIND_CLEAR,
    KIND_NOP
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_DONE
  } back_state_e;

  typedef struct packed {
    logic [31:0]        handle;
    logic [31:0]        source;
    logic [31:0]        payload;
    logic signed [15:0] prio;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    cmd_kind_e          kind;
    logic [31:0]        source;
    logic [31:0]        payload;
    logic signed [15:0] prio;
    logic [31:0]        target;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] new_handle;
    logic        active_valid;
    slot_t       active;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/priority_override_table_unit.sv @@
// Top level of the priority override table: front end, command queue and
// back end with the slot RAM. Uses pot_pkg, pot_front and pot_back.
//
// Usage:
//   Input channel is a queue write side: a transaction is taken at a clock
//   edge with push high and full low. action selects push (0), remove by
//   handle (1) or clear (2); action 3 is a no-op that still reports.
//   Result channel is a queue read side: while empty is low the result of
//   the oldest transaction is on the result ports; it is taken with pop.
//   Every transaction gives exactly one result, in order.
//   Command flow: the back end works on one command at a time. It runs
//   an execute step, a 16-slot scan at one RAM read per cycle with
//   registered read data, and a step to post the result; the scan goes
//   through the single RAM read port. A two-entry command queue in front
//   lets up to two further transactions be taken meanwhile.
//   When the receiver stalls, one finished result is held; the back end
//   then waits and the command queue fills, after which full rises.
//   Reset empties the table, sets the next handle to 1 and drops all
//   queued transactions and results. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module priority_override_table_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         action_i,
  input  wire logic [31:0]        source_tag_i,
  input  wire logic [31:0]        payload_tag_i,
  input  wire logic               payload_present_i,
  input  wire logic signed [15:0] priority_req_i,
  input  wire logic [31:0]        target_handle_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              status_o,
  output logic [31:0]             new_handle_o,
  output logic                    active_valid_o,
  output logic [31:0]             active_handle_o,
  output logic [31:0]             active_source_o,
  output logic [31:0]             active_payload_o,
  output logic signed [15:0]      active_priority_o
);

  logic          cmd_valid;
  logic          cmd_ready;
  pot_pkg::cmd_t cmd;
  pot_pkg::res_t res;

  pot_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .action_i          (action_i),
    .source_tag_i      (source_tag_i),
    .payload_tag_i     (payload_tag_i),
    .payload_present_i (payload_present_i),
    .priority_req_i    (priority_req_i),
    .target_handle_i   (target_handle_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_ready_i       (cmd_ready)
  );

  pot_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign status_o          = res.status;
  assign new_handle_o      = res.new_handle;
  assign active_valid_o    = res.active_valid;
  assign active_handle_o   = res.active.handle;
  assign active_source_o   = res.active.source;
  assign active_payload_o  = res.active.payload;
  assign active_priority_o = res.active.prio;

endmodule

`default_nettype wire

@@ hdl/pot_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the slot records of the table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/pot_front.sv @@
// Front end: accepts input transactions, classifies them into commands
// and buffers them in a short queue for the back end. Uses pot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pot_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [31:0]        source_tag_i,
  input  wire logic [31:0]        payload_tag_i,
  input  wire logic               payload_present_i,
  input  wire logic signed [15:0] priority_req_i,
  input  wire logic [31:0]        target_handle_i,
  output logic                    cmd_valid_o,
  output pot_pkg::cmd_t           cmd_o,
  input  wire logic               cmd_ready_i
);

  pot_pkg::cmd_t                        cmdq_q [pot_pkg::CMDQ_DEPTH];
  logic [pot_pkg::CMDQ_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [pot_pkg::CMDQ_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [pot_pkg::CMDQ_CNT_W-1:0]       cnt_q, cnt_d;
  pot_pkg::cmd_t                        cmd_new;
  logic                                 wr_en, rd_en;

  // classify the incoming transaction
  always_comb begin
    cmd_new.source  = source_tag_i;
    cmd_new.payload = payload_tag_i;
    cmd_new.prio    = priority_req_i;
    cmd_new.target  = target_handle_i;
    unique case (action_i)
      pot_pkg::ACT_PUSH:   cmd_new.kind = payload_present_i ? pot_pkg::KIND_PUSH
                                                            : pot_pkg::KIND_REJECT;
      pot_pkg::ACT_REMOVE: cmd_new.kind = pot_pkg::KIND_REMOVE;
      pot_pkg::ACT_CLEAR:  cmd_new.kind = pot_pkg::KIND_CLEAR;
      default:             cmd_new.kind = pot_pkg::KIND_NOP;
    endcase
  end

  assign full_o      = (cnt_q == pot_pkg::CMDQ_CNT_W'(pot_pkg::CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmdq_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmdq_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pot_back.sv @@
// Back end: executes commands against the slot table and scans all slots
// for the active entry, one slot per cycle. Uses pot_pkg and pot_ram.
`timescale 1ns / 1ps
`default_nettype none

module pot_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire pot_pkg::cmd_t cmd_i,
  output logic               cmd_ready_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output pot_pkg::res_t      res_o
);

  localparam logic [pot_pkg::IDX_W-1:0] LastIdx = pot_pkg::IDX_W'(pot_pkg::TABLE_DEPTH - 1);

  pot_pkg::back_state_e               state_q, state_d;
  logic [pot_pkg::TABLE_DEPTH-1:0]    used_q, used_d;
  logic [31:0]                        next_handle_q, next_handle_d;
  pot_pkg::cmd_kind_e                 kind_q, kind_d;
  logic [31:0]                        target_q, target_d;
  pot_pkg::status_e                   status_q, status_d;
  logic [31:0]                        new_handle_q, new_handle_d;
  logic                               removed_q, removed_d;
  logic [pot_pkg::IDX_W-1:0]          rd_idx_q, rd_idx_d;
  logic                               issued_q, issued_d;
  logic                               chk_vld_q, chk_vld_d;
  logic [pot_pkg::IDX_W-1:0]          chk_idx_q, chk_idx_d;
  logic                               best_vld_q, best_vld_d;
  pot_pkg::slot_t                     best_q, best_d;
  logic                               res_vld_q, res_vld_d;
  pot_pkg::res_t                      res_q, res_d;

  logic                               accept;
  logic                               tbl_full;
  logic [pot_pkg::IDX_W-1:0]          free_idx;
  logic                               ram_we;
  pot_pkg::slot_t                     ram_wdata;
  pot_pkg::slot_t                     ram_rdata;
  logic                               res_free;
  logic                               scan_last;
  logic                               better;

  pot_ram #(
    .WIDTH (pot_pkg::SLOT_W),
    .DEPTH (pot_pkg::TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = pot_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = pot_pkg::IDX_W'(i);
      end
    end
  end

  assign tbl_full  = &used_q;
  assign res_free  = !res_vld_q || pop_i;
  assign scan_last = chk_vld_q && (chk_idx_q == LastIdx);
  assign accept    = cmd_valid_i && cmd_ready_o;

  assign ram_wdata.handle  = next_handle_q;
  assign ram_wdata.source  = cmd_i.source;
  assign ram_wdata.payload = cmd_i.payload;
  assign ram_wdata.prio    = cmd_i.prio;

  // higher priority wins, ties go to the larger handle, full ties keep the lower slot
  assign better = !best_vld_q
               || ($signed(ram_rdata.prio) > $signed(best_q.prio))
               || (($signed(ram_rdata.prio) == $signed(best_q.prio))
                   && (ram_rdata.handle > best_q.handle));

  // FSM next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pot_pkg::BS_IDLE: if (cmd_valid_i) state_d = pot_pkg::BS_SCAN;
      pot_pkg::BS_SCAN: if (scan_last)   state_d = pot_pkg::BS_DONE;
      pot_pkg::BS_DONE: if (res_free)    state_d = pot_pkg::BS_IDLE;
      default:                           state_d = pot_pkg::BS_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    cmd_ready_o = (state_q == pot_pkg::BS_IDLE);
    ram_we      = (state_q == pot_pkg::BS_IDLE) && cmd_valid_i
               && (cmd_i.kind == pot_pkg::KIND_PUSH) && !tbl_full;
  end

  // datapath
  always_comb begin
    used_d        = used_q;
    next_handle_d = next_handle_q;
    kind_d        = kind_q;
    target_d      = target_q;
    status_d      = status_q;
    new_handle_d  = new_handle_q;
    removed_d     = removed_q;
    rd_idx_d      = rd_idx_q;
    issued_d      = issued_q;
    chk_vld_d     = 1'b0;
    chk_idx_d     = chk_idx_q;
    best_vld_d    = best_vld_q;
    best_d        = best_q;
    res_vld_d     = res_vld_q;
    res_d         = res_q;

    if (pop_i && res_vld_q) begin
      res_vld_d = 1'b0;
    end

    unique case (state_q)
      pot_pkg::BS_IDLE: begin
        if (accept) begin
          kind_d       = cmd_i.kind;
          target_d     = cmd_i.target;
          new_handle_d = '0;
          removed_d    = 1'b0;
          rd_idx_d     = '0;
          issued_d     = 1'b0;
          best_vld_d   = 1'b0;
          unique case (cmd_i.kind)
            pot_pkg::KIND_PUSH: begin
              if (tbl_full) begin
                status_d = pot_pkg::ST_FULL;
              end else begin
                status_d         = pot_pkg::ST_OK;
                used_d[free_idx] = 1'b1;
                new_handle_d     = next_handle_q;
                // zero is never handed out
                next_handle_d    = (next_handle_q == '1) ? 32'd1 : next_handle_q + 32'd1;
              end
            end
            pot_pkg::KIND_REJECT: status_d = pot_pkg::ST_EMPTY;
            pot_pkg::KIND_REMOVE: status_d = pot_pkg::ST_NOTFOUND;
            pot_pkg::KIND_CLEAR: begin
              status_d = pot_pkg::ST_OK;
              used_d   = '0;
            end
            default: status_d = pot_pkg::ST_OK;
          endcase
        end
      end

      pot_pkg::BS_SCAN: begin
        // read issue side
        chk_vld_d = !issued_q;
        chk_idx_d = rd_idx_q;
        if (!issued_q) begin
          if (rd_idx_q == LastIdx) begin
            issued_d = 1'b1;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        // data side: remove first match, otherwise compete for active
        if (chk_vld_q && used_q[chk_idx_q]) begin
          if ((kind_q == pot_pkg::KIND_REMOVE) && !removed_q
              && (ram_rdata.handle == target_q)) begin
            used_d[chk_idx_q] = 1'b0;
            removed_d         = 1'b1;
            status_d          = pot_pkg::ST_OK;
          end else if (better) begin
            best_vld_d = 1'b1;
            best_d     = ram_rdata;
          end
        end
      end

      pot_pkg::BS_DONE: begin
        if (res_free) begin
          res_vld_d          = 1'b1;
          res_d.status       = status_q;
          res_d.new_handle   = new_handle_q;
          res_d.active_valid = best_vld_q;
          res_d.active       = best_vld_q ? best_q : '0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pot_pkg::BS_IDLE;
      used_q        <= '0;
      next_handle_q <= 32'd1;
      issued_q      <= 1'b0;
      chk_vld_q     <= 1'b0;
      res_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      used_q        <= used_d;
      next_handle_q <= next_handle_d;
      issued_q      <= issued_d;
      chk_vld_q     <= chk_vld_d;
      res_vld_q     <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    target_q     <= target_d;
    status_q     <= status_d;
    new_handle_q <= new_handle_d;
    removed_q    <= removed_d;
    rd_idx_q     <= rd_idx_d;
    chk_idx_q    <= chk_idx_d;
    best_vld_q   <= best_vld_d;
    best_q       <= best_d;
    res_q        <= res_d;
  end

  assign empty_o = !res_vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ hdl/pot_checker.sv @@
// Port-level checker for priority_override_table_unit, bound to the top.
// Uses pot_pkg status codes.
`timescale 1ns / 1ps
`default_nettype none

module pot_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  status_o,
  input wire logic [31:0] new_handle_o,
  input wire logic        active_valid_o,
  input wire logic [31:0] active_handle_o,
  input wire logic [31:0] active_source_o,
  input wire logic [31:0] active_payload_o,
  input wire logic [15:0] active_priority_o
);

  // a waiting result holds until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(status_o) && $stable(new_handle_o)
                       && $stable(active_handle_o))
    else $error("result changed while stalled");

  // no active entry reports all-zero fields
  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !active_valid_o |-> active_handle_o == '0 && active_source_o == '0
                                  && active_payload_o == '0 && active_priority_o == '0)
    else $error("inactive result carries data");

  // only a successful push hands out a handle
  a_handle_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && new_handle_o != '0 |-> status_o == pot_pkg::ST_OK && active_valid_o)
    else $error("handle given without a stored entry");

  // handle zero is never stored
  a_active_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && active_valid_o |-> active_handle_o != '0)
    else $error("active entry has handle zero");

endmodule

bind priority_override_table_unit pot_checker u_pot_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .empty             (empty),
  .pop               (pop),
  .status_o          (status_o),
  .new_handle_o      (new_handle_o),
  .active_valid_o    (active_valid_o),
  .active_handle_o   (active_handle_o),
  .active_source_o   (active_source_o),
  .active_payload_o  (active_payload_o),
  .active_priority_o (active_priority_o)
);

`default_nettype wire

@@ bench/pot_checker.sv @@
// Scoreboard for the priority override table: watches both queue ports,
// keeps its own copy of the slot table and compares every popped result.
// Depends on pot_pkg for the slot, result, action and status types.
`timescale 1ns / 1ps

module pot_scoreboard (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  input  wire logic               full,
  input  wire logic [1:0]         action_i,
  input  wire logic [31:0]        source_tag_i,
  input  wire logic [31:0]        payload_tag_i,
  input  wire logic               payload_present_i,
  input  wire logic signed [15:0] priority_req_i,
  input  wire logic [31:0]        target_handle_i,
  input  wire logic               empty,
  input  wire logic               pop,
  input  wire logic [1:0]         status_o,
  input  wire logic [31:0]        new_handle_o,
  input  wire logic               active_valid_o,
  input  wire logic [31:0]        active_handle_o,
  input  wire logic [31:0]        active_source_o,
  input  wire logic [31:0]        active_payload_o,
  input  wire logic signed [15:0] active_priority_o,
  output int                      fail_count_o,
  output int                      outstanding_o,
  output int                      checked_o,
  output int                      full_refusals_o,
  output int                      missed_removes_o
);

  pot_pkg::slot_t entries    [pot_pkg::TABLE_DEPTH];
  bit             entry_live [pot_pkg::TABLE_DEPTH];
  logic [31:0]    next_hdl;
  pot_pkg::res_t  expected_results [$];

  int mismatches;
  int checked;
  int full_refusals;
  int missed_removes;

  assign fail_count_o     = mismatches;
  assign checked_o        = checked;
  assign full_refusals_o  = full_refusals;
  assign missed_removes_o = missed_removes;

  task automatic flag(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input int idx);
    if (got !== want)
      flag($sformatf("result %0d %s got %h want %h", idx, name, got, want));
  endtask

  // Executes one command on the table copy and returns the report it causes.
  function automatic pot_pkg::res_t apply_command(input logic [1:0] act,
                                                  input logic [31:0] src,
                                                  input logic [31:0] pay,
                                                  input logic present,
                                                  input logic signed [15:0] prio,
                                                  input logic [31:0] tgt);
    pot_pkg::res_t r;
    bit            done;
    int            best;
    r        = '0;
    r.status = pot_pkg::ST_OK;
    done     = 1'b0;
    best     = -1;
    case (act)
      pot_pkg::ACT_PUSH: begin
        if (!present) begin
          r.status = pot_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < pot_pkg::TABLE_DEPTH; i++) begin
            if (!done && !entry_live[i]) begin
              entry_live[i] = 1'b1;
              entries[i]    = '{handle: next_hdl, source: src, payload: pay, prio: prio};
              r.new_handle  = next_hdl;
              next_hdl      = next_hdl + 32'd1;
              if (next_hdl == 32'd0) next_hdl = 32'd1;
              done = 1'b1;
            end
          end
          if (!done) begin
            r.status = pot_pkg::ST_FULL;
            full_refusals++;
          end
        end
      end
      pot_pkg::ACT_REMOVE: begin
        // lowest matching slot only
        for (int i = 0; i < pot_pkg::TABLE_DEPTH; i++) begin
          if (!done && entry_live[i] && entries[i].handle == tgt) begin
            entry_live[i] = 1'b0;
            done = 1'b1;
          end
        end
        if (!done) begin
          r.status = pot_pkg::ST_NOTFOUND;
          missed_removes++;
        end
      end
      pot_pkg::ACT_CLEAR: begin
        for (int i = 0; i < pot_pkg::TABLE_DEPTH; i++) entry_live[i] = 1'b0;
      end
      default: ;
    endcase
    // highest priority wins, larger handle on a tie, lowest slot on a full tie
    for (int i = 0; i < pot_pkg::TABLE_DEPTH; i++) begin
      if (entry_live[i]) begin
        if (best < 0 || entries[i].prio > entries[best].prio ||
            (entries[i].prio == entries[best].prio &&
             entries[i].handle > entries[best].handle))
          best = i;
      end
    end
    if (best >= 0) begin
      r.active_valid = 1'b1;
      r.active       = entries[best];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pot_pkg::res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < pot_pkg::TABLE_DEPTH; i++) begin
        entry_live[i] = 1'b0;
        entries[i]    = '0;
      end
      next_hdl = 32'd1;
      expected_results.delete();
      mismatches     = 0;
      checked        = 0;
      full_refusals  = 0;
      missed_removes = 0;
      outstanding_o <= 0;
    end else begin
      // a result can never belong to a command taken at the same edge
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          flag($sformatf("result with nothing outstanding, status %0d", status_o));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(status_o), 32'(want.status), checked);
          check_field("new_handle", new_handle_o, want.new_handle, checked);
          check_field("active_valid", 32'(active_valid_o), 32'(want.active_valid), checked);
          check_field("active_handle", active_handle_o, want.active.handle, checked);
          check_field("active_source", active_source_o, want.active.source, checked);
          check_field("active_payload", active_payload_o, want.active.payload, checked);
          check_field("active_priority", 32'(active_priority_o), 32'(want.active.prio),
                      checked);
        end
        checked++;
      end
      if (push && !full)
        expected_results.insert(expected_results.size(),
                                apply_command(action_i, source_tag_i, payload_tag_i,
                                              payload_present_i, priority_req_i,
                                              target_handle_i));
      outstanding_o <= expected_results.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the priority override table bench: clock, reset, paced stimulus
// on the command queue, random popping of results, watchdog and verdict.
// Depends on pot_pkg, priority_override_table_unit and pot_scoreboard.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] ACT_NOP       = 2'd3;
  localparam int         RANDOM_ITEMS  = 850;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         DRAIN_CYCLES  = 40;
  localparam int         HANDLE_MEMORY = 32;

  typedef struct {
    logic [1:0]         act;
    logic [31:0]        src;
    logic [31:0]        pay;
    logic               present;
    logic signed [15:0] prio;
    logic [31:0]        tgt;
  } override_req_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               push              = 1'b0;
  logic               pop               = 1'b0;
  logic [1:0]         action_i          = '0;
  logic [31:0]        source_tag_i      = '0;
  logic [31:0]        payload_tag_i     = '0;
  logic               payload_present_i = 1'b0;
  logic signed [15:0] priority_req_i    = '0;
  logic [31:0]        target_handle_i   = '0;
  logic               full;
  logic               empty;
  logic [1:0]         status_o;
  logic [31:0]        new_handle_o;
  logic               active_valid_o;
  logic [31:0]        active_handle_o;
  logic [31:0]        active_source_o;
  logic [31:0]        active_payload_o;
  logic signed [15:0] active_priority_o;

  int fail_count;
  int outstanding;
  int checked;
  int full_refusals;
  int missed_removes;

  int          send_idle = 23;
  int          recv_idle = 54;
  int          stall_cycles = 0;
  logic [31:0] recent_handles [$];
  logic [31:0] last_active = '0;

  priority_override_table_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .action_i          (action_i),
    .source_tag_i      (source_tag_i),
    .payload_tag_i     (payload_tag_i),
    .payload_present_i (payload_present_i),
    .priority_req_i    (priority_req_i),
    .target_handle_i   (target_handle_i),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .new_handle_o      (new_handle_o),
    .active_valid_o    (active_valid_o),
    .active_handle_o   (active_handle_o),
    .active_source_o   (active_source_o),
    .active_payload_o  (active_payload_o),
    .active_priority_o (active_priority_o)
  );

  pot_scoreboard u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .action_i          (action_i),
    .source_tag_i      (source_tag_i),
    .payload_tag_i     (payload_tag_i),
    .payload_present_i (payload_present_i),
    .priority_req_i    (priority_req_i),
    .target_handle_i   (target_handle_i),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .new_handle_o      (new_handle_o),
    .active_valid_o    (active_valid_o),
    .active_handle_o   (active_handle_o),
    .active_source_o   (active_source_o),
    .active_payload_o  (active_payload_o),
    .active_priority_o (active_priority_o),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding),
    .checked_o         (checked),
    .full_refusals_o   (full_refusals),
    .missed_removes_o  (missed_removes)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle);
  end

  // remember handles the block gave out, so removes mostly hit live entries
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (new_handle_o != 32'd0) recent_handles.insert(recent_handles.size(), new_handle_o);
      if (recent_handles.size() > HANDLE_MEMORY) void'(recent_handles.pop_front());
      last_active <= active_handle_o;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic override_req_t req(input logic [1:0] act, input logic [31:0] src,
                                        input logic [31:0] pay, input logic present,
                                        input logic signed [15:0] prio,
                                        input logic [31:0] tgt);
    override_req_t c;
    c.act     = act;
    c.src     = src;
    c.pay     = pay;
    c.present = present;
    c.prio    = prio;
    c.tgt     = tgt;
    return c;
  endfunction

  // small values give frequent ties, the rest spreads over the full range
  function automatic logic signed [15:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($signed($urandom_range(0, 4)) - 2);
    if (r < 50) return 16'sh7FFF;
    if (r < 60) return 16'sh8000;
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65 && recent_handles.size() > 0)
      return recent_handles[$urandom_range(0, recent_handles.size() - 1)];
    if (r < 80) return last_active;
    if (r < 88) return 32'd0;
    return $urandom;
  endfunction

  function automatic override_req_t random_request();
    override_req_t c;
    int r;
    c = req(pot_pkg::ACT_PUSH, $urandom, $urandom, 1'b1, pick_prio(), $urandom);
    r = $urandom_range(0, 99);
    if (r < 52) begin
      c.act = pot_pkg::ACT_PUSH;
    end else if (r < 58) begin
      c.present = 1'b0;
    end else if (r < 90) begin
      c.act = pot_pkg::ACT_REMOVE;
      c.tgt = pick_target();
    end else if (r < 93) begin
      c.act = pot_pkg::ACT_CLEAR;
    end else if (r < 96) begin
      c.act = ACT_NOP;
    end else begin
      // push with a stray handle field and no payload
      c.present = 1'b0;
      c.tgt     = 32'hFFFF_FFFF;
    end
    return c;
  endfunction

  task automatic issue(input override_req_t c);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push              <= 1'b1;
    action_i          <= c.act;
    source_tag_i      <= c.src;
    payload_tag_i     <= c.pay;
    payload_present_i <= c.present;
    priority_req_i    <= c.prio;
    target_handle_i   <= c.tgt;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners on an empty table
    issue(req(pot_pkg::ACT_REMOVE, '1, '1, 1'b1, 16'sh7FFF, 32'd0));
    issue(req(pot_pkg::ACT_CLEAR, '1, '1, 1'b1, 16'sh8000, '1));
    issue(req(ACT_NOP, '1, '1, 1'b1, 16'sh7FFF, '1));
    issue(req(pot_pkg::ACT_PUSH, '1, '1, 1'b0, 16'sh7FFF, '1));
    // handles 1..3; the third ties the first and is newer
    issue(req(pot_pkg::ACT_PUSH, '1, '1, 1'b1, 16'sh7FFF, '0));
    issue(req(pot_pkg::ACT_PUSH, '0, '0, 1'b1, 16'sh8000, '0));
    issue(req(pot_pkg::ACT_PUSH, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, 16'sh7FFF, '0));
    issue(req(pot_pkg::ACT_REMOVE, '0, '0, 1'b0, '0, 32'd3));
    issue(req(pot_pkg::ACT_REMOVE, '0, '0, 1'b0, '0, 32'hFFFF_FFFF));
    // fill the table to the last slot
    for (int i = 0; i < 14; i++)
      issue(req(pot_pkg::ACT_PUSH, $urandom, $urandom, 1'b1,
                (i % 3 == 0) ? 16'sh7FFF : 16'(i - 7), $urandom));
    issue(req(pot_pkg::ACT_PUSH, '1, '1, 1'b1, 16'sh7FFF, '0));
    issue(req(pot_pkg::ACT_PUSH, '1, '1, 1'b0, 16'sh7FFF, '0));
    issue(req(pot_pkg::ACT_REMOVE, '0, '0, 1'b1, '0, 32'd1));
    issue(req(pot_pkg::ACT_PUSH, 32'h0123_4567, 32'h89AB_CDEF, 1'b1, 16'sh7FFF, '0));
    issue(req(pot_pkg::ACT_CLEAR, '0, '0, 1'b0, '0, '0));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 23; recv_idle = 54; end
        1: begin send_idle = 54; recv_idle = 23; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      repeat (RANDOM_ITEMS / 3 + (phase == 0 ? RANDOM_ITEMS % 3 : 0))
        issue(random_request());
    end
    push <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d transactions over three pacing phases plus corner cases",
             checked);
    $display("table-full refusals %0d, removes of unknown handles %0d, leftovers %0d",
             full_refusals, missed_removes, outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pot_pkg.sv
hdl/pot_ram.sv
hdl/pot_front.sv
hdl/pot_back.sv
hdl/priority_override_table_unit.sv
hdl/pot_checker.sv
bench/pot_checker.sv
bench/tb_top.sv
